>>> rtl/sfas_pkg.sv
// shared types, codes and field widths of the sprite animation sequencer
package sfas_pkg;

    localparam int CMD_W  = 2;
    localparam int CHF_W  = 2;
    localparam int IDX_W  = 5;
    localparam int TICK_W = 16;
    localparam int OFS_W  = 16;
    localparam int TOT_W  = 6;
    localparam int MASK_W = 4;
    localparam int KIND_W = 2;
    // wide enough for any frame index, frame count or frame limit
    localparam int CMP_W  = 9;
    localparam int ENTRY_W = TICK_W + 2 * OFS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BIND   = 2'd1,
        CMD_UNBIND = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_BIND  = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BIND,
        ST_UNBIND,
        ST_VISIT,
        ST_READ,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_we;
        logic bind_ch;
        logic unbind_ch;
        logic visit;
        logic finish;
        logic done;
        logic vis_next;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic vis_read;
        logic vis_last;
    } t_stat;

endpackage

>>> rtl/sfas_ram.sv
// generic single-port-write, registered-read ram
module sfas_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sfas_ctrl.sv
// command sequencer: walks each command through its states
module sfas_ctrl import sfas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] i_command,
    input  t_stat            i_stat,
    output t_ctrl            o_ctrl,
    output logic             busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (t_cmd'(i_command))
                        CMD_LOAD:   n_state = ST_LOAD;
                        CMD_BIND:   n_state = ST_BIND;
                        CMD_UNBIND: n_state = ST_UNBIND;
                        CMD_TICK:   n_state = ST_VISIT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD, ST_BIND, ST_UNBIND, ST_DONE: n_state = ST_IDLE;
            ST_VISIT: begin
                priority if (i_stat.vis_read) begin
                    n_state = ST_READ;
                end else if (i_stat.vis_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_VISIT;
                end
            end
            ST_READ: n_state = i_stat.vis_last ? ST_DONE : ST_VISIT;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        busy   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy           = 1'b0;
                o_ctrl.capture = start;
            end
            ST_LOAD:   o_ctrl.load_we   = 1'b1;
            ST_BIND:   o_ctrl.bind_ch   = 1'b1;
            ST_UNBIND: o_ctrl.unbind_ch = 1'b1;
            ST_VISIT: begin
                o_ctrl.visit    = 1'b1;
                o_ctrl.vis_next = !i_stat.vis_read;
            end
            ST_READ: begin
                o_ctrl.finish   = 1'b1;
                o_ctrl.vis_next = 1'b1;
            end
            ST_DONE:   o_ctrl.done = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

>>> rtl/sfas_dp.sv
// channel state, frame table and result registers
module sfas_dp import sfas_pkg::*; #(
    parameter int CHANNELS   = 4,
    parameter int MAX_FRAMES = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    output t_stat                    o_stat,
    input  logic [CHF_W-1:0]         i_channel,
    input  logic [IDX_W-1:0]         i_frame_slot_index,
    input  logic [TICK_W-1:0]        i_frame_ticks,
    input  logic signed [OFS_W-1:0]  i_shift_x,
    input  logic signed [OFS_W-1:0]  i_shift_y,
    input  logic [TOT_W-1:0]         i_frame_total_in,
    input  logic                     i_repeat_in,
    input  logic [MASK_W-1:0]        i_present_mask,
    input  logic [MASK_W-1:0]        i_stage_ok_mask,
    output logic                     o_result_valid,
    output logic [KIND_W-1:0]        o_kind,
    output logic [CHF_W-1:0]         o_out_channel,
    output logic                     o_buffer_slot,
    output logic [IDX_W-1:0]         o_shown_frame,
    output logic signed [OFS_W-1:0]  o_offset_x_out,
    output logic signed [OFS_W-1:0]  o_offset_y_out,
    output logic                     o_accepted,
    output logic                     o_last
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int DEPTH = CHANNELS * MAX_FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] ch,
                                              input logic [FW-1:0] fr);
        return AW'(32'(ch) * MAX_FRAMES + 32'(fr));
    endfunction

    // captured command fields
    logic [CHF_W-1:0]  r_channel;
    logic [IDX_W-1:0]  r_idx;
    logic [TICK_W-1:0] r_ticks_in;
    logic [OFS_W-1:0]  r_sx;
    logic [OFS_W-1:0]  r_sy;
    logic [TOT_W-1:0]  r_total_in;
    logic              r_rep_in;
    logic [MASK_W-1:0] r_pmask;
    logic [MASK_W-1:0] r_smask;

    // per-channel state
    logic [TOT_W-1:0]  r_total   [CHANNELS];
    logic [TOT_W-1:0]  n_total   [CHANNELS];
    logic              r_rep     [CHANNELS];
    logic              n_rep     [CHANNELS];
    logic [TICK_W-1:0] r_ticks   [CHANNELS];
    logic [TICK_W-1:0] n_ticks   [CHANNELS];
    logic [FW-1:0]     r_cur     [CHANNELS];
    logic [FW-1:0]     n_cur     [CHANNELS];
    logic              r_slot    [CHANNELS];
    logic              n_slot    [CHANNELS];
    logic              r_bound   [CHANNELS];
    logic              n_bound   [CHANNELS];
    logic              r_run     [CHANNELS];
    logic              n_run     [CHANNELS];
    logic              r_refresh [CHANNELS];
    logic              n_refresh [CHANNELS];

    // visit pointer and pending presentation
    logic [CW-1:0] r_vis, n_vis;
    logic [FW-1:0] r_pend_frame, n_pend_frame;
    logic          r_pend_slot, n_pend_slot;
    logic          r_pend_new, n_pend_new;

    // result registers
    logic              r_valid, n_valid;
    t_kind             r_kind, n_kind;
    logic [CHF_W-1:0]  r_och, n_och;
    logic              r_oslot, n_oslot;
    logic [IDX_W-1:0]  r_oframe, n_oframe;
    logic [OFS_W-1:0]  r_ox, n_ox;
    logic [OFS_W-1:0]  r_oy, n_oy;
    logic              r_oacc, n_oacc;
    logic              r_olast, n_olast;

    // command decode
    logic [CW-1:0] cmd_ch;
    logic          ch_ok;
    logic          idx_ok;
    logic          bind_ok;

    assign cmd_ch  = CW'(r_channel);
    assign ch_ok   = 32'(r_channel) < CHANNELS;
    assign idx_ok  = 32'(r_idx) < MAX_FRAMES;
    assign bind_ok = ch_ok && (r_total_in != '0) && (CMP_W'(r_total_in) <= CMP_W'(MAX_FRAMES));

    // visit decode
    logic            can, ok;
    logic [FW:0]     next_w;
    logic            wrap;
    logic            v_read, v_new, v_slot, v_set_refresh, v_dec, v_hold;
    logic [FW-1:0]   v_frame;

    assign can    = (32'(r_vis) < MASK_W) && r_pmask[2'(r_vis)];
    assign ok     = (32'(r_vis) < MASK_W) && r_smask[2'(r_vis)];
    assign next_w = {1'b0, r_cur[r_vis]} + 1'b1;
    assign wrap   = CMP_W'(next_w) >= CMP_W'(r_total[r_vis]);

    always_comb begin
        v_read        = 1'b0;
        v_new         = 1'b0;
        v_slot        = 1'b0;
        v_frame       = '0;
        v_set_refresh = 1'b0;
        v_dec         = 1'b0;
        v_hold        = 1'b0;
        if (r_bound[r_vis]) begin
            priority if (!can) begin
                v_set_refresh = r_run[r_vis];
            end else if (!r_run[r_vis]) begin
                v_read = ok;
                v_new  = 1'b1;
            end else if (r_refresh[r_vis]) begin
                v_read  = ok && (CMP_W'(r_cur[r_vis]) < CMP_W'(r_total[r_vis]));
                v_frame = r_cur[r_vis];
                v_slot  = r_slot[r_vis];
            end else if (r_ticks[r_vis] > TICK_W'(1)) begin
                v_dec = 1'b1;
            end else if (wrap && !r_rep[r_vis]) begin
                v_hold = 1'b1;
            end else begin
                v_read  = ok;
                v_new   = 1'b1;
                v_frame = wrap ? '0 : next_w[FW-1:0];
                v_slot  = !r_slot[r_vis];
            end
        end
    end

    assign o_stat.vis_read = v_read;
    assign o_stat.vis_last = (r_vis == CW'(CHANNELS - 1));

    // frame table: duration, x offset, y offset
    logic [ENTRY_W-1:0] rd_entry;
    logic [TICK_W-1:0]  rd_dur;

    sfas_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_ctrl.load_we && ch_ok && idx_ok),
        .i_waddr(f_addr(cmd_ch, FW'(r_idx))),
        .i_wdata({r_ticks_in, r_sx, r_sy}),
        .i_raddr(f_addr(r_vis, v_frame)),
        .o_rdata(rd_entry)
    );

    assign rd_dur = rd_entry[ENTRY_W-1 -: TICK_W];

    // state update
    always_comb begin
        n_total      = r_total;
        n_rep        = r_rep;
        n_ticks      = r_ticks;
        n_cur        = r_cur;
        n_slot       = r_slot;
        n_bound      = r_bound;
        n_run        = r_run;
        n_refresh    = r_refresh;
        n_vis        = r_vis;
        n_pend_frame = r_pend_frame;
        n_pend_slot  = r_pend_slot;
        n_pend_new   = r_pend_new;

        if (i_ctrl.capture) begin
            n_vis = '0;
        end
        if (i_ctrl.vis_next) begin
            n_vis = r_vis + 1'b1;
        end

        if (i_ctrl.visit) begin
            if (v_set_refresh) begin
                n_refresh[r_vis] = 1'b1;
            end
            if (v_dec) begin
                n_ticks[r_vis] = r_ticks[r_vis] - 1'b1;
            end
            if (v_hold) begin
                n_ticks[r_vis] = TICK_W'(1);
            end
            if (v_read) begin
                n_pend_frame = v_frame;
                n_pend_slot  = v_slot;
                n_pend_new   = v_new;
            end
        end

        if (i_ctrl.finish) begin
            n_refresh[r_vis] = 1'b0;
            if (r_pend_new) begin
                n_cur[r_vis]   = r_pend_frame;
                n_slot[r_vis]  = r_pend_slot;
                n_ticks[r_vis] = (rd_dur == '0) ? TICK_W'(1) : rd_dur;
                n_run[r_vis]   = 1'b1;
            end
        end

        // bind restarts from the unstarted state, unbind clears
        if ((i_ctrl.bind_ch && bind_ok) || (i_ctrl.unbind_ch && ch_ok)) begin
            n_total[cmd_ch]   = '0;
            n_rep[cmd_ch]     = 1'b0;
            n_ticks[cmd_ch]   = '0;
            n_cur[cmd_ch]     = '0;
            n_slot[cmd_ch]    = 1'b0;
            n_bound[cmd_ch]   = 1'b0;
            n_run[cmd_ch]     = 1'b0;
            n_refresh[cmd_ch] = 1'b0;
            if (i_ctrl.bind_ch) begin
                n_total[cmd_ch] = r_total_in;
                n_rep[cmd_ch]   = r_rep_in;
                n_bound[cmd_ch] = 1'b1;
            end
        end
    end

    // result build
    always_comb begin
        n_valid  = 1'b0;
        n_kind   = r_kind;
        n_och    = r_och;
        n_oslot  = r_oslot;
        n_oframe = r_oframe;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_oacc   = r_oacc;
        n_olast  = r_olast;
        if (i_ctrl.finish || i_ctrl.bind_ch || (i_ctrl.unbind_ch && ch_ok) || i_ctrl.done) begin
            n_valid  = 1'b1;
            n_och    = '0;
            n_oslot  = 1'b0;
            n_oframe = '0;
            n_ox     = '0;
            n_oy     = '0;
            n_oacc   = 1'b0;
            n_olast  = 1'b1;
            priority if (i_ctrl.finish) begin
                n_kind   = KIND_FRAME;
                n_och    = CHF_W'(r_vis);
                n_oslot  = r_pend_slot;
                n_oframe = IDX_W'(r_pend_frame);
                n_ox     = rd_entry[2*OFS_W-1 -: OFS_W];
                n_oy     = rd_entry[OFS_W-1:0];
                n_olast  = 1'b0;
            end else if (i_ctrl.bind_ch) begin
                n_kind = KIND_BIND;
                n_och  = r_channel;
                n_oacc = bind_ok;
            end else if (i_ctrl.unbind_ch) begin
                n_kind = KIND_CLEAR;
                n_och  = r_channel;
            end else begin
                n_kind = KIND_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis   <= '0;
            r_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_total[c]   <= '0;
                r_rep[c]     <= 1'b0;
                r_ticks[c]   <= '0;
                r_cur[c]     <= '0;
                r_slot[c]    <= 1'b0;
                r_bound[c]   <= 1'b0;
                r_run[c]     <= 1'b0;
                r_refresh[c] <= 1'b0;
            end
        end else begin
            r_vis     <= n_vis;
            r_valid   <= n_valid;
            r_total   <= n_total;
            r_rep     <= n_rep;
            r_ticks   <= n_ticks;
            r_cur     <= n_cur;
            r_slot    <= n_slot;
            r_bound   <= n_bound;
            r_run     <= n_run;
            r_refresh <= n_refresh;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_channel  <= i_channel;
            r_idx      <= i_frame_slot_index;
            r_ticks_in <= i_frame_ticks;
            r_sx       <= i_shift_x;
            r_sy       <= i_shift_y;
            r_total_in <= i_frame_total_in;
            r_rep_in   <= i_repeat_in;
            r_pmask    <= i_present_mask;
            r_smask    <= i_stage_ok_mask;
        end
        r_pend_frame <= n_pend_frame;
        r_pend_slot  <= n_pend_slot;
        r_pend_new   <= n_pend_new;
        r_kind       <= n_kind;
        r_och        <= n_och;
        r_oslot      <= n_oslot;
        r_oframe     <= n_oframe;
        r_ox         <= n_ox;
        r_oy         <= n_oy;
        r_oacc       <= n_oacc;
        r_olast      <= n_olast;
    end

    assign o_result_valid = r_valid;
    assign o_kind         = r_kind;
    assign o_out_channel  = r_och;
    assign o_buffer_slot  = r_oslot;
    assign o_shown_frame  = r_oframe;
    assign o_offset_x_out = r_ox;
    assign o_offset_y_out = r_oy;
    assign o_accepted     = r_oacc;
    assign o_last         = r_olast;

endmodule

>>> rtl/sprite_frame_animation_sequencer_unit.sv
// top level of the sprite frame animation sequencer
//
// channel    | handshake                       | payload
// -----------+---------------------------------+-------------------------------------------
// command in | start, busy (taken: start&&!busy)| i_command .. i_stage_ok_mask
// result out | o_result_valid, one-cycle strobe | o_kind .. o_last
//
// load, bind and unbind keep busy high for one cycle after the transaction
// a tick keeps busy high while it visits each channel in turn, with an extra
//   frame-table read state (single read port) for each channel that presents a
//   frame, and then a done state for the tick-done result
// reset is synchronous, active low; the frame table keeps no reset value
// results leave through an output register in the cycle after they are formed
//   and cannot be held off by the receiver
module sprite_frame_animation_sequencer_unit import sfas_pkg::*; #(
    parameter int CHANNELS   = 4,
    parameter int MAX_FRAMES = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command transaction
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [CHF_W-1:0]        i_channel,
    input  logic [IDX_W-1:0]        i_frame_slot_index,
    input  logic [TICK_W-1:0]       i_frame_ticks,
    input  logic signed [OFS_W-1:0] i_shift_x,
    input  logic signed [OFS_W-1:0] i_shift_y,
    input  logic [TOT_W-1:0]        i_frame_total_in,
    input  logic                    i_repeat_in,
    input  logic [MASK_W-1:0]       i_present_mask,
    input  logic [MASK_W-1:0]       i_stage_ok_mask,
    // result transaction
    output logic                    o_result_valid,
    output logic [KIND_W-1:0]       o_kind,
    output logic [CHF_W-1:0]        o_out_channel,
    output logic                    o_buffer_slot,
    output logic [IDX_W-1:0]        o_shown_frame,
    output logic signed [OFS_W-1:0] o_offset_x_out,
    output logic signed [OFS_W-1:0] o_offset_y_out,
    output logic                    o_accepted,
    output logic                    o_last
);

    // sequencer commands and datapath status
    t_ctrl ctrl;
    t_stat stat;

    // state machine: one state per command step, tick walks the channels
    sfas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_command(i_command),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .busy     (busy)
    );

    // per-channel animation state, frame table and result register
    sfas_dp #(
        .CHANNELS  (CHANNELS),
        .MAX_FRAMES(MAX_FRAMES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .i_channel         (i_channel),
        .i_frame_slot_index(i_frame_slot_index),
        .i_frame_ticks     (i_frame_ticks),
        .i_shift_x         (i_shift_x),
        .i_shift_y         (i_shift_y),
        .i_frame_total_in  (i_frame_total_in),
        .i_repeat_in       (i_repeat_in),
        .i_present_mask    (i_present_mask),
        .i_stage_ok_mask   (i_stage_ok_mask),
        .o_result_valid    (o_result_valid),
        .o_kind            (o_kind),
        .o_out_channel     (o_out_channel),
        .o_buffer_slot     (o_buffer_slot),
        .o_shown_frame     (o_shown_frame),
        .o_offset_x_out    (o_offset_x_out),
        .o_offset_y_out    (o_offset_y_out),
        .o_accepted        (o_accepted),
        .o_last            (o_last)
    );

endmodule

>>> rtl/sfas_checker.sv
// port-level checks of the sequencer and their bind to the top level
module sfas_checker import sfas_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input logic [KIND_W-1:0] o_kind,
    input logic [CHF_W-1:0]  o_out_channel,
    input logic              o_last
);

    // every accepted transaction raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // the final result of a transaction coincides with the return to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |-> !busy)
        else $error("final result while still busy");

    // only frame presentations are followed by further results
    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> busy && (o_kind == KIND_FRAME))
        else $error("non-final result is not a frame presentation");

    // tick done closes the tick and names no channel
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_kind == KIND_DONE) |-> o_last && (o_out_channel == '0))
        else $error("malformed tick-done result");

endmodule

bind sprite_frame_animation_sequencer_unit sfas_checker u_sfas_checker (.*);
